[rtl/core/tnop_pkg.sv]
// Package for the triangle normal octahedral packer: widths, beat layouts and shared types.
`timescale 1ns / 1ps
`default_nettype none
package tnop_pkg;

  localparam int CoordBits = 16;
  localparam int EdgeW     = CoordBits + 1;
  localparam int ProdW     = 2 * EdgeW;
  localparam int NormW     = ProdW + 1;
  localparam int SumW      = ProdW + 1;
  localparam int TermW     = SumW + 1;
  localparam int RemW      = SumW + 9;
  localparam int CodeW     = 8;
  localparam int NumCells  = CodeW;
  localparam int InDataW   = 9 * CoordBits;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_FLOOR   = 2'd1,
    KIND_CEILING = 2'd2,
    KIND_UNUSED  = 2'd3
  } flat_kind_t;

  // One beat travelling down the divider chain.
  typedef struct packed {
    logic             valid;
    logic [RemW-1:0]  rem_u;
    logic [RemW-1:0]  rem_v;
    logic [RemW-1:0]  dsh;
    logic [CodeW-1:0] q_u;
    logic [CodeW-1:0] q_v;
    logic             flip;
    logic             degen;
  } cell_t;

endpackage
`default_nettype wire

[rtl/core/tnop_div_cell.sv]
// One cell of the divider chain: settles one quotient bit of both codes per beat.
`timescale 1ns / 1ps
`default_nettype none
module tnop_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire tnop_pkg::cell_t din,
  output tnop_pkg::cell_t      dout
);
  import tnop_pkg::*;

  logic [RemW:0] diff_u;
  logic [RemW:0] diff_v;
  cell_t         res;

  always_comb begin
    diff_u = {1'b0, din.rem_u} - {1'b0, din.dsh};
    diff_v = {1'b0, din.rem_v} - {1'b0, din.dsh};
    res    = din;
    // A clear borrow bit means the shifted divisor fits into the remainder.
    res.rem_u = diff_u[RemW] ? din.rem_u : diff_u[RemW-1:0];
    res.rem_v = diff_v[RemW] ? din.rem_v : diff_v[RemW-1:0];
    res.q_u   = {din.q_u[CodeW-2:0], ~diff_u[RemW]};
    res.q_v   = {din.q_v[CodeW-2:0], ~diff_v[RemW]};
    res.dsh   = din.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.rem_u <= res.rem_u;
      dout.rem_v <= res.rem_v;
      dout.dsh   <= res.dsh;
      dout.q_u   <= res.q_u;
      dout.q_v   <= res.q_v;
      dout.flip  <= res.flip;
      dout.degen <= res.degen;
    end
  end

endmodule
`default_nettype wire

[rtl/core/tnop_front.sv]
// Front pipeline: edges, cross product, flat flip, L1 sum and dividend set-up.
`timescale 1ns / 1ps
`default_nettype none
module tnop_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [tnop_pkg::InDataW-1:0]   in_coords,
  input  wire logic [1:0]                     in_kind,
  output tnop_pkg::cell_t                     dout
);
  import tnop_pkg::*;

  logic signed [CoordBits-1:0] c [9];

  // Stage 1: edges
  logic                    v1;
  logic signed [EdgeW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  flat_kind_t              k1;
  // Stage 2: products
  logic                    v2;
  logic signed [ProdW-1:0] p0, p1, p2, p3, p4, p5;
  flat_kind_t              k2;
  // Stage 3: normal after flat rule
  logic                    v3;
  logic signed [NormW-1:0] nx, ny, nz;
  logic                    f3;
  logic signed [NormW-1:0] cx, cy, cz;
  logic                    flip_c;
  // Stage 4: magnitudes and L1 sum
  logic                    v4;
  logic signed [NormW-1:0] nx4, ny4;
  logic [NormW-1:0]        mx, my;
  logic                    sx, sy, sz;
  logic [SumW-1:0]         s4;
  logic                    f4;
  logic [NormW-1:0]        ax, ay, az;
  // Stage 5: shifted numerators
  logic                    v5;
  logic [TermW-1:0]        tu, tv;
  logic [SumW-1:0]         s5;
  logic                    f5, d5;
  logic [TermW-1:0]        s2;

  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign c[i] = in_coords[i*CoordBits +: CoordBits];
  end

  always_comb begin
    cx = NormW'(p0) - NormW'(p1);
    cy = NormW'(p2) - NormW'(p3);
    cz = NormW'(p4) - NormW'(p5);
    unique case (k2)
      KIND_FLOOR:   flip_c = cy[NormW-1];
      KIND_CEILING: flip_c = !cy[NormW-1] && (cy != '0);
      default:      flip_c = 1'b0;
    endcase
    ax = nx[NormW-1] ? NormW'(-nx) : NormW'(nx);
    ay = ny[NormW-1] ? NormW'(-ny) : NormW'(ny);
    az = nz[NormW-1] ? NormW'(-nz) : NormW'(nz);
    s2 = {s4, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dout.valid <= v5;
    end
    if (en) begin
      e1x <= EdgeW'(c[3]) - EdgeW'(c[0]);
      e1y <= EdgeW'(c[4]) - EdgeW'(c[1]);
      e1z <= EdgeW'(c[5]) - EdgeW'(c[2]);
      e2x <= EdgeW'(c[6]) - EdgeW'(c[0]);
      e2y <= EdgeW'(c[7]) - EdgeW'(c[1]);
      e2z <= EdgeW'(c[8]) - EdgeW'(c[2]);
      k1  <= flat_kind_t'(in_kind);

      p0 <= e1y * e2z;
      p1 <= e1z * e2y;
      p2 <= e1z * e2x;
      p3 <= e1x * e2z;
      p4 <= e1x * e2y;
      p5 <= e1y * e2x;
      k2 <= k1;

      nx <= flip_c ? NormW'(-cx) : cx;
      ny <= flip_c ? NormW'(-cy) : cy;
      nz <= flip_c ? NormW'(-cz) : cz;
      f3 <= flip_c;

      nx4 <= nx;
      ny4 <= ny;
      mx  <= ax;
      my  <= ay;
      sx  <= nx[NormW-1];
      sy  <= ny[NormW-1];
      sz  <= nz[NormW-1];
      s4  <= SumW'(ax) + SumW'(ay) + SumW'(az);
      f4  <= f3;

      // A negative z folds the point into the outer triangles of the square.
      if (sz) begin
        tu <= sx ? TermW'(my) : s2 - TermW'(my);
        tv <= sy ? TermW'(mx) : s2 - TermW'(mx);
      end else begin
        tu <= TermW'(nx4) + TermW'(s4);
        tv <= TermW'(ny4) + TermW'(s4);
      end
      s5 <= s4;
      f5 <= f4;
      d5 <= (s4 == '0);

      dout.rem_u <= (RemW'(tu) << 8) - RemW'(tu) + RemW'(s5);
      dout.rem_v <= (RemW'(tv) << 8) - RemW'(tv) + RemW'(s5);
      dout.dsh   <= RemW'(s5) << 8;
      dout.q_u   <= '0;
      dout.q_v   <= '0;
      dout.flip  <= f5;
      dout.degen <= d5;
    end
  end

endmodule
`default_nettype wire

[rtl/core/triangle_normal_octa_pack.sv]
// Top level of the triangle normal octahedral packer.
// Usage:
//   Slave channel: one triangle per beat. s_tdata holds the nine vertex
//   coordinates, s_tuser the flat kind. Master channel: one beat per
//   triangle with the two octahedral codes in m_tdata and two flags in
//   m_tuser.
//   An accepted input beat reaches m_tvalid through six front stages,
//   eight divider cells and the output register.
//   Throughput is one triangle per cycle while the receiver does not stall; the chain of eight divider cells,
//   each deciding one code bit, sets the depth.
//   All stages advance together whenever the output register is empty or
//   being drained, so s_tready follows m_tready while a result waits.
//   A stalled receiver freezes the whole pipeline; nothing is dropped.
//   Reset clears all valid bits; no other register is reset.
//   A zero cross product yields both codes zero with degenerate set.
`timescale 1ns / 1ps
`default_nettype none
module triangle_normal_octa_pack (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (16 bits each)
  input  wire logic [143:0] s_tdata,
  // flat_kind
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // oct_u, oct_v
  output logic [15:0]      m_tdata,
  // was_flipped, degenerate
  output logic [1:0]       m_tuser
);
  import tnop_pkg::*;

  logic  en;
  cell_t chain [NumCells+1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  tnop_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_coords (s_tdata[InDataW-1:0]),
    .in_kind   (s_tuser),
    .dout      (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    tnop_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain[NumCells].valid;
    end
    if (en) begin
      m_tdata <= chain[NumCells].degen ? '0 : {chain[NumCells].q_v, chain[NumCells].q_u};
      m_tuser <= {chain[NumCells].degen, chain[NumCells].flip};
    end
  end

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '0)
    else $error("degenerate result with nonzero codes");

  a_degen_noflip : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("degenerate result marked as flipped");

  a_ready_follows : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipeline stalled");

endmodule
`default_nettype wire
